// ===== rtl/cdts_pkg.sv =====
// Shared types, constants and helper functions for the calendar date/time stepper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cdts_pkg;

  // Request kinds carried in tuser
  localparam logic [1:0] REQ_UP   = 2'd0;
  localparam logic [1:0] REQ_DOWN = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;

  // Unit selector for step requests
  localparam logic [2:0] UNIT_MINUTE = 3'd0;
  localparam logic [2:0] UNIT_HOUR   = 3'd1;
  localparam logic [2:0] UNIT_DAY    = 3'd2;
  localparam logic [2:0] UNIT_MONTH  = 3'd3;
  localparam logic [2:0] UNIT_YEAR   = 3'd4;

  // Value limits
  localparam logic signed [15:0] YEAR_MAX = 16'sd16799;
  localparam logic signed [15:0] YEAR_MIN = -16'sd12998;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;

  // Year bias: a multiple of 400 that makes every legal year positive and
  // keeps it a multiple of 16, so the low year bits still give year mod 16.
  localparam logic [16:0] YEAR_BIAS = 17'd13200;
  // Reciprocal of 25 scaled by 2^20; exact quotient for any 15-bit value
  localparam logic [15:0] RECIP_25  = 16'd41944;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [4:0] RES_LAST   = 5'd24;
  // Residues mod 25 of the biased year at the two ends of the range
  localparam logic [4:0] RES_AT_MAX = 5'd24;
  localparam logic [4:0] RES_AT_MIN = 5'd2;

  // Date and time held by the block, with the biased year mod 25
  typedef struct packed {
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [4:0]         res25;
  } cdts_time_t;

  // Year 2000 biased is 15200, a multiple of 25
  localparam cdts_time_t RESET_TIME = '{
    year: 16'sd2000, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0, res25: 5'd0
  };

  // Leap when divisible by 4 and not by 100, or divisible by 400
  function automatic logic is_leap(input logic [3:0] year_lo, input logic [4:0] res25);
    logic div4;
    logic div25;
    div4  = (year_lo[1:0] == 2'd0);
    div25 = (res25 == 5'd0);
    return div4 && (!div25 || (year_lo == 4'd0));
  endfunction

  // Days in a month; codes outside 1..12 read as 31
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/cdts_mod25.sv =====
// Residue mod 25 of a biased year, by reciprocal multiply and back-subtraction.
// Depends on cdts_pkg.
`timescale 1ns / 1ps

module cdts_mod25
  import cdts_pkg::*;
(
  input  logic signed [15:0] year_i,
  output logic [4:0]         res25_o
);

  logic [16:0] biased;
  logic [14:0] val;
  logic [30:0] prod;
  logic [10:0] quot;
  logic [15:0] quot_x25;
  logic [15:0] rem;

  // Legal years map onto 202..29999 once biased
  assign biased   = {year_i[15], year_i} + YEAR_BIAS;
  assign val      = biased[14:0];

  // Quotient by reciprocal, then remainder
  assign prod     = 31'(val) * 31'(RECIP_25);
  assign quot     = prod[30:RECIP_SHIFT];
  assign quot_x25 = 16'(quot) * 16'd25;
  assign rem      = 16'(val) - quot_x25;
  assign res25_o  = rem[4:0];

endmodule

// ===== rtl/cdts_next.sv =====
// Next-state logic: load, or a one-unit step with carry, borrow and day clamp.
// Depends on cdts_pkg.
`timescale 1ns / 1ps

module cdts_next
  import cdts_pkg::*;
(
  input  cdts_time_t cur_i,
  input  logic [1:0] req_type_i,
  input  logic [2:0] unit_i,
  input  cdts_time_t load_i,   // year already clamped, res25 already valid
  output cdts_time_t nxt_o
);

  logic       leap_cur;
  logic       leap_up;
  logic       leap_dn;
  logic       leap_ld;
  logic [4:0] len_cur;
  logic [4:0] len_clamp;
  logic [3:0] mon_inc;
  logic [3:0] mon_dec;
  logic [3:0] ld_month;
  logic [4:0] ld_len;
  logic       do_day_up;
  logic       do_day_dn;
  logic       do_clamp;
  cdts_time_t yr_up;
  cdts_time_t yr_dn;
  cdts_time_t stp;

  // Neighbouring years with their residues, wrapping at the range ends
  always_comb begin
    yr_up = cur_i;
    yr_dn = cur_i;
    if (cur_i.year >= YEAR_MAX) begin
      yr_up.year  = YEAR_MIN;
      yr_up.res25 = RES_AT_MIN;
    end else begin
      yr_up.year  = cur_i.year + 16'sd1;
      yr_up.res25 = (cur_i.res25 == RES_LAST) ? 5'd0 : cur_i.res25 + 5'd1;
    end
    if (cur_i.year <= YEAR_MIN) begin
      yr_dn.year  = YEAR_MAX;
      yr_dn.res25 = RES_AT_MAX;
    end else begin
      yr_dn.year  = cur_i.year - 16'sd1;
      yr_dn.res25 = (cur_i.res25 == 5'd0) ? RES_LAST : cur_i.res25 - 5'd1;
    end
  end

  assign leap_cur = is_leap(cur_i.year[3:0], cur_i.res25);
  assign leap_up  = is_leap(yr_up.year[3:0], yr_up.res25);
  assign leap_dn  = is_leap(yr_dn.year[3:0], yr_dn.res25);
  assign len_cur  = month_len(cur_i.month, leap_cur);
  assign mon_inc  = (cur_i.month >= MONTH_MAX) ? 4'd1 : cur_i.month + 4'd1;
  assign mon_dec  = (cur_i.month <= 4'd1) ? MONTH_MAX : cur_i.month - 4'd1;

  // Load path clamps
  assign ld_month = (load_i.month == 4'd0) ? 4'd1 :
                    (load_i.month > MONTH_MAX) ? MONTH_MAX : load_i.month;
  assign leap_ld  = is_leap(load_i.year[3:0], load_i.res25);
  assign ld_len   = month_len(ld_month, leap_ld);

  // Step path: minute and hour set carry flags, then day, month and year act
  always_comb begin
    stp       = cur_i;
    do_day_up = 1'b0;
    do_day_dn = 1'b0;
    do_clamp  = 1'b0;
    len_clamp = len_cur;
    case (unit_i)
      UNIT_MINUTE: begin
        if (req_type_i == REQ_UP) begin
          if (cur_i.minute >= MINUTE_MAX) begin
            stp.minute = 6'd0;
            if (cur_i.hour >= HOUR_MAX) begin
              stp.hour  = 5'd0;
              do_day_up = 1'b1;
            end else begin
              stp.hour = cur_i.hour + 5'd1;
            end
          end else begin
            stp.minute = cur_i.minute + 6'd1;
          end
        end else begin
          if (cur_i.minute == 6'd0) begin
            stp.minute = MINUTE_MAX;
            if (cur_i.hour == 5'd0) begin
              stp.hour  = HOUR_MAX;
              do_day_dn = 1'b1;
            end else begin
              stp.hour = cur_i.hour - 5'd1;
            end
          end else begin
            stp.minute = cur_i.minute - 6'd1;
          end
        end
      end
      UNIT_HOUR: begin
        if (req_type_i == REQ_UP) begin
          if (cur_i.hour >= HOUR_MAX) begin
            stp.hour  = 5'd0;
            do_day_up = 1'b1;
          end else begin
            stp.hour = cur_i.hour + 5'd1;
          end
        end else begin
          if (cur_i.hour == 5'd0) begin
            stp.hour  = HOUR_MAX;
            do_day_dn = 1'b1;
          end else begin
            stp.hour = cur_i.hour - 5'd1;
          end
        end
      end
      UNIT_DAY: begin
        do_day_up = (req_type_i == REQ_UP);
        do_day_dn = (req_type_i != REQ_UP);
      end
      UNIT_MONTH: begin
        if (req_type_i == REQ_UP) begin
          stp.month = mon_inc;
          // December rolls into January of the next year, 31 days
          if (cur_i.month >= MONTH_MAX) begin
            stp.year  = yr_up.year;
            stp.res25 = yr_up.res25;
          end
        end else begin
          stp.month = mon_dec;
          if (cur_i.month <= 4'd1) begin
            stp.year  = yr_dn.year;
            stp.res25 = yr_dn.res25;
          end
        end
        do_clamp  = 1'b1;
        len_clamp = month_len(stp.month, leap_cur);
      end
      UNIT_YEAR: begin
        if (req_type_i == REQ_UP) begin
          stp.year  = yr_up.year;
          stp.res25 = yr_up.res25;
          len_clamp = month_len(cur_i.month, leap_up);
        end else begin
          stp.year  = yr_dn.year;
          stp.res25 = yr_dn.res25;
          len_clamp = month_len(cur_i.month, leap_dn);
        end
        do_clamp = 1'b1;
      end
      default: begin
        stp = cur_i;
      end
    endcase

    // Day carry into month and year
    if (do_day_up) begin
      if (cur_i.day >= len_cur) begin
        stp.day   = 5'd1;
        stp.month = mon_inc;
        if (cur_i.month >= MONTH_MAX) begin
          stp.year  = yr_up.year;
          stp.res25 = yr_up.res25;
        end
      end else begin
        stp.day = cur_i.day + 5'd1;
      end
    end

    // Day borrow lands on the last day of the previous month
    if (do_day_dn) begin
      if (cur_i.day <= 5'd1) begin
        stp.month = mon_dec;
        if (cur_i.month <= 4'd1) begin
          stp.year  = yr_dn.year;
          stp.res25 = yr_dn.res25;
          stp.day   = month_len(MONTH_MAX, leap_dn);
        end else begin
          stp.day = month_len(mon_dec, leap_cur);
        end
      end else begin
        stp.day = cur_i.day - 5'd1;
      end
    end

    if (do_clamp && (cur_i.day > len_clamp)) begin
      stp.day = len_clamp;
    end
  end

  // Select by request kind
  always_comb begin
    nxt_o = cur_i;
    case (req_type_i)
      REQ_LOAD: begin
        nxt_o.year   = load_i.year;
        nxt_o.res25  = load_i.res25;
        nxt_o.month  = ld_month;
        nxt_o.day    = (load_i.day == 5'd0) ? 5'd1 :
                       (load_i.day > ld_len) ? ld_len : load_i.day;
        nxt_o.hour   = (load_i.hour > HOUR_MAX) ? HOUR_MAX : load_i.hour;
        nxt_o.minute = (load_i.minute > MINUTE_MAX) ? MINUTE_MAX : load_i.minute;
      end
      REQ_UP:   nxt_o = stp;
      REQ_DOWN: nxt_o = stp;
      default:  nxt_o = cur_i;
    endcase
  end

endmodule

// ===== rtl/calendar_datetime_stepper.sv =====
// Gregorian date/time stepper top level: input register, next-state logic and
// the date/time registers that also form the result. Depends on cdts_pkg,
// cdts_mod25 and cdts_next.
// Throughput: one request per cycle unless the output stalls; the single pass
// from the input register through the next-state logic into the date/time
// registers sets this.
// Reset: asynchronous, clears both valid flags and sets 2000-01-01 00:00.
`timescale 1ns / 1ps

module calendar_datetime_stepper
  import cdts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // load_year[15:0], load_month[19:16], load_day[24:20], load_hour[29:25],
  // load_minute[35:30], zero [39:36]
  input  logic [39:0] s_axis_tdata_i,
  // req_type[1:0], unit[4:2]
  input  logic [4:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // cur_year[15:0], cur_month[19:16], cur_day[24:20], cur_hour[29:25],
  // cur_minute[35:30], zero [39:36]
  output logic [39:0] m_axis_tdata_o
);

  logic signed [15:0] ld_year_raw;
  logic signed [15:0] ld_year_clamped;
  logic [4:0]         ld_res25;
  logic               in_valid_q;
  logic [1:0]         req_type_q;
  logic [2:0]         unit_q;
  cdts_time_t         load_q;
  cdts_time_t         state_q;
  cdts_time_t         state_d;
  logic               out_valid_q;
  logic               advance;

  // Year saturation and its residue, ahead of the input register
  assign ld_year_raw     = s_axis_tdata_i[15:0];
  assign ld_year_clamped = (ld_year_raw < YEAR_MIN) ? YEAR_MIN :
                           (ld_year_raw > YEAR_MAX) ? YEAR_MAX : ld_year_raw;

  cdts_mod25 u_mod25 (
    .year_i  (ld_year_clamped),
    .res25_o (ld_res25)
  );

  // Handshake: the stage moves when the result slot is empty or being taken
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      req_type_q    <= s_axis_tuser_i[1:0];
      unit_q        <= s_axis_tuser_i[4:2];
      load_q.year   <= ld_year_clamped;
      load_q.res25  <= ld_res25;
      load_q.month  <= s_axis_tdata_i[19:16];
      load_q.day    <= s_axis_tdata_i[24:20];
      load_q.hour   <= s_axis_tdata_i[29:25];
      load_q.minute <= s_axis_tdata_i[35:30];
    end
  end

  cdts_next u_next (
    .cur_i      (state_q),
    .req_type_i (req_type_q),
    .unit_i     (unit_q),
    .load_i     (load_q),
    .nxt_o      (state_d)
  );

  // Date/time registers double as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= RESET_TIME;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, state_q.minute, state_q.hour, state_q.day,
                            state_q.month, state_q.year};

  // Checks on the held date and the stage control
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.month >= 4'd1) && (state_q.month <= MONTH_MAX) &&
    (state_q.hour <= HOUR_MAX) && (state_q.minute <= MINUTE_MAX))
    else $error("date/time registers out of range");

  a_day_fits_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.day >= 5'd1) &&
    (state_q.day <= month_len(state_q.month, is_leap(state_q.year[3:0], state_q.res25))))
    else $error("day exceeds month length");

  a_res25_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.res25 <= RES_LAST)
    else $error("year residue out of range");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled with empty result slot");

  a_hold_without_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("date/time changed without a request");

endmodule
